// File: rtl/core/time_slice_task_scheduler_assert.svh
// assertion macros for the time slice task scheduler checker
`ifndef TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH
`define TIME_SLICE_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define TSTS_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("scheduler port check failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define TSTS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("scheduler port check failed");

`endif

// File: rtl/core/tsts_pkg.sv
// shared types, field layout and codes for the time slice task scheduler
package tsts_pkg;

	localparam int ID_W       = 5;
	localparam int FIELD_W    = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;

	// input tdata layout
	localparam int IN_ID_LSB  = 0;
	localparam int IN_W_LSB   = 5;
	localparam int IN_S_LSB   = 21;
	localparam int IN_RUN_BIT = 37;

	// output tdata layout
	localparam int OUT_SW_BIT    = 5;
	localparam int OUT_SLICE_LSB = 6;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_CONT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SCHED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REFILL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NONE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_WRITE  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLICE = 4'd1;

	typedef struct packed {
		logic                in_load;
		logic                wr_entry;
		logic                rd_cur;
		logic                dec_cur;
		logic                idx_clr;
		logic                scan_issue;
		logic                ref_issue;
		logic                take_pick;
		logic                take_idle;
		logic                status_ld;
		logic [STATUS_W-1:0] status_val;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic dec_ok;
		logic dec_last;
		logic idx_last;
		logic pick_none;
		logic out_busy;
	} sts_t;

endpackage

// File: rtl/core/tsts_ctrl.sv
// sequencer for writes, ticks, selection scans and refill sweeps
module tsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_func,
	input  tsts_pkg::sts_t  sts,
	output tsts_pkg::cmd_t  cmd,
	output logic            in_ready
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WRITE  = 4'd1;
	localparam logic [3:0] S_TRD    = 4'd2;
	localparam logic [3:0] S_TCHK   = 4'd3;
	localparam logic [3:0] S_SCAN   = 4'd4;
	localparam logic [3:0] S_SDRAIN = 4'd5;
	localparam logic [3:0] S_SRES   = 4'd6;
	localparam logic [3:0] S_REF    = 4'd7;
	localparam logic [3:0] S_RDRAIN = 4'd8;
	localparam logic [3:0] S_FRD    = 4'd9;
	localparam logic [3:0] S_FIN    = 4'd10;

	logic [3:0] state_q, state_d;
	logic       pass2_q, pass2_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pass2_q <= pass2_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		pass2_d = pass2_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.in_load = 1'b1;
					state_d = (s_func == tsts_pkg::FUNC_WRITE) ? S_WRITE : S_TRD;
				end
			end
			S_WRITE: begin
				cmd.wr_entry   = 1'b1;
				cmd.status_ld  = 1'b1;
				cmd.status_val = tsts_pkg::ST_WRITE;
				state_d        = S_FRD;
			end
			S_TRD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_TCHK;
			end
			S_TCHK: begin
				cmd.dec_cur = sts.dec_ok;
				if (sts.dec_ok && !sts.dec_last) begin
					cmd.status_ld  = 1'b1;
					cmd.status_val = tsts_pkg::ST_CONT;
					state_d        = S_FRD;
				end else begin
					cmd.idx_clr = 1'b1;
					pass2_d     = 1'b0;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SDRAIN;
				end
			end
			S_SDRAIN: begin
				state_d = S_SRES;
			end
			S_SRES: begin
				if (!sts.pick_none) begin
					cmd.take_pick  = 1'b1;
					cmd.status_ld  = 1'b1;
					cmd.status_val = pass2_q ? tsts_pkg::ST_REFILL : tsts_pkg::ST_SCHED;
					state_d        = S_FRD;
				end else if (!pass2_q) begin
					cmd.idx_clr = 1'b1;
					pass2_d     = 1'b1;
					state_d     = S_REF;
				end else begin
					cmd.take_idle  = 1'b1;
					cmd.status_ld  = 1'b1;
					cmd.status_val = tsts_pkg::ST_NONE;
					state_d        = S_FRD;
				end
			end
			S_REF: begin
				cmd.ref_issue = 1'b1;
				if (sts.idx_last) begin
					state_d = S_RDRAIN;
				end
			end
			S_RDRAIN: begin
				// last refill write lands here, rescan starts after it
				cmd.idx_clr = 1'b1;
				state_d     = S_SCAN;
			end
			S_FRD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/tsts_dpath.sv
// task table memory, scan compare, refill arithmetic and result register
module tsts_dpath #(
	parameter int TASK_COUNT = 32,
	parameter int SLICE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsts_pkg::cmd_t                      cmd,
	output tsts_pkg::sts_t                      sts,
	input  logic [tsts_pkg::IN_DATA_W-1:0]      in_data,
	input  logic                                cfg_wr,
	input  logic [tsts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsts_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [tsts_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [tsts_pkg::STATUS_W-1:0]       m_tuser
);

	localparam int IDX_W = (TASK_COUNT > 2) ? $clog2(TASK_COUNT) : 1;
	localparam int CMP_W = ((SLICE_BITS > tsts_pkg::CFG_DATA_W) ?
		SLICE_BITS : tsts_pkg::CFG_DATA_W) + 1;
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TASK_COUNT - 1);
	localparam logic [SLICE_BITS-1:0] SLICE_MAX = '1;

	// latched input item
	logic [tsts_pkg::ID_W-1:0] in_id_q;
	logic [SLICE_BITS-1:0]     in_w_q;
	logic [SLICE_BITS-1:0]     in_s_q;
	logic                      in_run_q;

	// configuration
	logic                             mode_q;
	logic [tsts_pkg::CFG_DATA_W-1:0]  max_slice_q;

	// task table: weight in the upper half, slice in the lower half
	logic [2*SLICE_BITS-1:0] task_mem_q [TASK_COUNT];
	logic [TASK_COUNT-1:0]   entry_vld_q;
	logic [TASK_COUNT-1:0]   run_mask_q;
	logic [2*SLICE_BITS-1:0] rd_data_q;
	logic                    rd_vld_q;

	logic [IDX_W-1:0] cur_q, prev_q, idx_q, pick_q;
	logic [CMP_W-1:0] best_q;
	logic [tsts_pkg::STATUS_W-1:0] status_q;

	logic             pipe_vld_s1, pipe_ref_s1;
	logic [IDX_W-1:0] pipe_idx_s1;

	logic                          out_vld_q, out_sw_q;
	logic [tsts_pkg::ID_W-1:0]     out_task_q;
	logic [tsts_pkg::FIELD_W-1:0]  out_slice_q;
	logic [tsts_pkg::STATUS_W-1:0] out_status_q;

	logic [IDX_W-1:0]        rd_addr, wr_addr, wr_id;
	logic                    rd_en, wr_en, id_in_range;
	logic [2*SLICE_BITS-1:0] wr_data;
	logic [SLICE_BITS-1:0]   rd_slice, rd_weight, dec_slice, refill_slice;
	logic [SLICE_BITS:0]     refill_sum;
	logic [CMP_W-1:0]        s_ext;
	logic                    cand_ok;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_id_q  <= in_data[tsts_pkg::IN_ID_LSB +: tsts_pkg::ID_W];
			in_w_q   <= SLICE_BITS'(in_data[tsts_pkg::IN_W_LSB +: tsts_pkg::FIELD_W]);
			in_s_q   <= SLICE_BITS'(in_data[tsts_pkg::IN_S_LSB +: tsts_pkg::FIELD_W]);
			in_run_q <= in_data[tsts_pkg::IN_RUN_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			max_slice_q <= '1;
		end else if (cfg_wr) begin
			case (cfg_index)
				tsts_pkg::CFG_MODE:      mode_q      <= cfg_data[0];
				tsts_pkg::CFG_MAX_SLICE: max_slice_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign rd_en       = cmd.rd_cur | cmd.scan_issue | cmd.ref_issue;
	assign rd_addr     = cmd.rd_cur ? cur_q : idx_q;
	assign id_in_range = 32'(in_id_q) < TASK_COUNT;
	assign wr_id       = IDX_W'(in_id_q);

	// an entry never written reads as zero
	assign rd_slice  = rd_vld_q ? rd_data_q[SLICE_BITS-1:0] : '0;
	assign rd_weight = rd_vld_q ? rd_data_q[2*SLICE_BITS-1:SLICE_BITS] : '0;
	assign dec_slice = rd_slice - SLICE_BITS'(1);

	assign refill_sum   = {1'b0, rd_slice >> 1} + {1'b0, rd_weight};
	assign refill_slice = mode_q ? rd_weight :
		(refill_sum[SLICE_BITS] ? SLICE_MAX : refill_sum[SLICE_BITS-1:0]);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = {rd_weight, dec_slice};
		if (cmd.wr_entry) begin
			wr_en   = id_in_range;
			wr_addr = wr_id;
			wr_data = {in_w_q, in_s_q};
		end else if (cmd.dec_cur) begin
			wr_en = 1'b1;
		end else if (pipe_vld_s1 && pipe_ref_s1) begin
			wr_en   = 1'b1;
			wr_addr = pipe_idx_s1;
			wr_data = {rd_weight, refill_slice};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			task_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= task_mem_q[rd_addr];
			rd_vld_q  <= entry_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			run_mask_q  <= '1;
		end else begin
			if (wr_en) begin
				entry_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.wr_entry && id_in_range) begin
				run_mask_q[wr_id] <= in_run_q;
			end
		end
	end

	// scan compare on the entry read in the previous cycle
	assign s_ext   = CMP_W'(rd_slice);
	assign cand_ok = run_mask_q[pipe_idx_s1] &&
		(mode_q ? ((rd_slice != '0) && (s_ext < best_q)) : (s_ext > best_q));

	always_ff @(posedge clk) begin
		if (cmd.idx_clr) begin
			best_q <= mode_q ? (CMP_W'(max_slice_q) + CMP_W'(1)) : '0;
			pick_q <= '0;
		end else if (pipe_vld_s1 && !pipe_ref_s1 && cand_ok) begin
			best_q <= s_ext;
			pick_q <= pipe_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pipe_vld_s1 <= 1'b0;
			pipe_ref_s1 <= 1'b0;
			pipe_idx_s1 <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			status_q    <= tsts_pkg::ST_CONT;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= IDX_W'(1);
			end else if (cmd.scan_issue || cmd.ref_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			pipe_vld_s1 <= cmd.scan_issue | cmd.ref_issue;
			pipe_ref_s1 <= cmd.ref_issue;
			pipe_idx_s1 <= idx_q;
			if (cmd.in_load) begin
				prev_q <= cur_q;
			end
			if (cmd.take_pick) begin
				cur_q <= pick_q;
			end else if (cmd.take_idle) begin
				cur_q <= '0;
			end
			if (cmd.status_ld) begin
				status_q <= cmd.status_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_task_q   <= tsts_pkg::ID_W'(cur_q);
			out_sw_q     <= (cur_q != prev_q);
			out_status_q <= status_q;
			out_slice_q  <= tsts_pkg::FIELD_W'(rd_slice);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_slice_q, out_sw_q, out_task_q};
	assign m_tuser  = out_status_q;

	assign sts.dec_ok    = (cur_q != '0) && (rd_slice != '0);
	assign sts.dec_last  = (rd_slice == SLICE_BITS'(1));
	assign sts.idx_last  = (idx_q == LAST_IDX);
	assign sts.pick_none = (pick_q == '0);
	assign sts.out_busy  = out_vld_q && !m_tready;

endmodule

// File: rtl/core/time_slice_task_scheduler.sv
// top level of the time slice task scheduler
//
//   channel  signals                               direction  carries
//   s_*      s_tvalid s_tready s_tdata s_tuser     in         write or tick item
//   m_*      m_tvalid m_tready m_tdata m_tuser     out        one result per item
//   cfg_*    cfg_valid cfg_ready cfg_index cfg_data in        register write
//
// a write item writes its entry, a tick that keeps the task decrements its slice, a tick
// that reschedules adds a selection sweep, one that needs a refill adds a refill sweep
// and a rescan; s_tready returns once the result is loaded into the m_* register
// the task table has one read port and is swept one entry per cycle in each pass
// one item is in work at a time; the next is accepted while the result waits on m_tready
// reset is asynchronous on arst_n and takes effect at once, per-entry valid bits
// make the table read as zero with no clearing pass
module time_slice_task_scheduler #(
	parameter int TASK_COUNT = 32,
	parameter int SLICE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// task_id[4:0] weight[20:5] start_slice[36:21] runnable[37], zero pad
	input  logic [tsts_pkg::IN_DATA_W-1:0]      s_tdata,
	// func[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// next_task[4:0] switched[5] remaining_slice[21:6], zero pad
	output logic [tsts_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status[2:0]
	output logic [tsts_pkg::STATUS_W-1:0]       m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tsts_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tsts_pkg::cmd_t cmd;
	tsts_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_func   (s_tuser),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	tsts_dpath #(
		.TASK_COUNT (TASK_COUNT),
		.SLICE_BITS (SLICE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// File: rtl/core/tsts_check.sv
// port checker for the scheduler result channel, bound to the top level
`include "time_slice_task_scheduler_assert.svh"

module tsts_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tsts_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [tsts_pkg::STATUS_W-1:0]   m_tuser
);

	// a stalled result holds
	`TSTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// keeping the task or writing an entry never switches
	`TSTS_ASSERT_NOW(a_no_switch, m_tvalid && (m_tuser == tsts_pkg::ST_CONT || m_tuser == tsts_pkg::ST_WRITE), !m_tdata[tsts_pkg::OUT_SW_BIT])

	// no ready task leaves the idle task running
	`TSTS_ASSERT_NOW(a_none_idle, m_tvalid && m_tuser == tsts_pkg::ST_NONE, m_tdata[tsts_pkg::ID_W-1:0] == '0)

	// only defined status codes come out
	`TSTS_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= tsts_pkg::ST_WRITE)

endmodule

bind time_slice_task_scheduler tsts_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/time_slice_task_scheduler_checker.sv
// scoreboard for the time slice task scheduler: mirrors the task table and checks every result
module time_slice_task_scheduler_checker #(
	parameter int TASK_COUNT = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [tsts_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [tsts_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic [tsts_pkg::STATUS_W-1:0]    m_tuser,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [tsts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsts_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsts_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]     next_task;
		logic                switched;
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  remaining_slice;
	} sched_result_t;

	logic [FIELD_W-1:0] slice_tab  [TASK_COUNT];
	logic [FIELD_W-1:0] weight_tab [TASK_COUNT];
	logic [TASK_COUNT-1:0] ready_mask;
	logic [ID_W-1:0]    cur_task;
	logic               sjf_mode;
	logic [FIELD_W-1:0] slice_limit;

	sched_result_t due_results[$];

	// one selection pass over entries 1 and up, zero when nothing qualifies
	function automatic logic [ID_W-1:0] pick_task();
		logic [ID_W-1:0]  pick;
		logic [FIELD_W:0] best;
		pick = '0;
		best = sjf_mode ? ({1'b0, slice_limit} + (FIELD_W+1)'(1)) : '0;
		for (int i = 1; i < TASK_COUNT; i++) begin
			if (ready_mask[i]) begin
				if (!sjf_mode && {1'b0, slice_tab[i]} > best) begin
					best = {1'b0, slice_tab[i]};
					pick = ID_W'(i);
				end else if (sjf_mode && slice_tab[i] != 0 && {1'b0, slice_tab[i]} < best) begin
					best = {1'b0, slice_tab[i]};
					pick = ID_W'(i);
				end
			end
		end
		return pick;
	endfunction

	// refill touches every entry but the idle one, runnable or not
	function automatic void refill_slices();
		logic [FIELD_W:0] sum;
		for (int i = 1; i < TASK_COUNT; i++) begin
			if (sjf_mode) begin
				slice_tab[i] = weight_tab[i];
			end else begin
				sum = {2'b0, slice_tab[i][FIELD_W-1:1]} + {1'b0, weight_tab[i]};
				slice_tab[i] = sum[FIELD_W] ? '1 : sum[FIELD_W-1:0];
			end
		end
	endfunction

	function automatic sched_result_t advance_scheduler(logic func, logic [ID_W-1:0] id,
		logic [FIELD_W-1:0] wgt, logic [FIELD_W-1:0] start, logic run);
		sched_result_t   res;
		logic [ID_W-1:0] prev;
		logic [ID_W-1:0] pick;
		logic            resched;
		prev = cur_task;
		if (func == FUNC_WRITE) begin
			if (id < TASK_COUNT) begin
				weight_tab[id] = wgt;
				slice_tab[id]  = start;
				ready_mask[id] = run;
			end
			res.status = ST_WRITE;
		end else begin
			resched = 1'b1;
			// a running task already at zero is not decremented
			if (cur_task != 0 && slice_tab[cur_task] != 0) begin
				slice_tab[cur_task] = slice_tab[cur_task] - FIELD_W'(1);
				if (slice_tab[cur_task] != 0)
					resched = 1'b0;
			end
			if (!resched) begin
				res.status = ST_CONT;
			end else begin
				pick = pick_task();
				res.status = ST_SCHED;
				if (pick == 0) begin
					refill_slices();
					pick = pick_task();
					res.status = (pick == 0) ? ST_NONE : ST_REFILL;
				end
				cur_task = pick;
			end
		end
		res.next_task       = cur_task;
		res.switched        = (cur_task != prev);
		res.remaining_slice = slice_tab[cur_task];
		return res;
	endfunction

	function automatic void report_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TASK_COUNT; i++) begin
				slice_tab[i]  = '0;
				weight_tab[i] = '0;
			end
			ready_mask  = '1;
			cur_task    = '0;
			sjf_mode    = 1'b0;
			slice_limit = '1;
			due_results.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			// results first: an item accepted on this edge cannot have answered yet
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t ns: expected no result, got task %0d status %0d slice %0d",
						$time, m_tdata[ID_W-1:0], m_tuser,
						m_tdata[OUT_SLICE_LSB +: FIELD_W]);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					report_field("next_task", want.next_task, m_tdata[ID_W-1:0]);
					report_field("switched", want.switched, m_tdata[OUT_SW_BIT]);
					report_field("status", want.status, m_tuser);
					report_field("remaining_slice", want.remaining_slice,
						m_tdata[OUT_SLICE_LSB +: FIELD_W]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MODE)
					sjf_mode = cfg_data[0];
				else if (cfg_index == CFG_MAX_SLICE)
					slice_limit = cfg_data;
			end
			if (s_tvalid && s_tready)
				due_results.push_back(advance_scheduler(s_tuser,
					s_tdata[IN_ID_LSB +: ID_W], s_tdata[IN_W_LSB +: FIELD_W],
					s_tdata[IN_S_LSB +: FIELD_W], s_tdata[IN_RUN_BIT]));
			pending = due_results.size();
		end
	end

endmodule

// File: tb/tb_time_slice_task_scheduler.sv
// stimulus and verdict for the time slice task scheduler
module tb_time_slice_task_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import tsts_pkg::*;

	localparam int TASK_COUNT = 32;
	localparam int SLICE_BITS = 16;
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 160;
	// a tick that needs a refill sweeps the table three times
	localparam int SETTLE     = 3 * TASK_COUNT + 14;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   s_tuser = FUNC_TICK;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     fail_count;
	int                     pending;
	logic                   quiet = 1'b0;
	int                     hold_left = 0;

	time_slice_task_scheduler #(
		.TASK_COUNT(TASK_COUNT),
		.SLICE_BITS(SLICE_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	time_slice_task_scheduler_checker #(
		.TASK_COUNT(TASK_COUNT)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #4 clk = ~clk;

	// result-side stalls in bursts of random length
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left--;
		else if (!quiet && $urandom_range(4) == 0)
			hold_left = $urandom_range(3, 1);
		m_tready <= (hold_left == 0);
	end

	// called just after a falling edge, returns just after a falling edge
	task automatic send_item(logic func, logic [ID_W-1:0] id, logic [FIELD_W-1:0] wgt,
		logic [FIELD_W-1:0] start, logic run);
		logic [IN_DATA_W-1:0] word;
		word = '0;
		word[IN_ID_LSB +: ID_W]   = id;
		word[IN_W_LSB +: FIELD_W] = wgt;
		word[IN_S_LSB +: FIELD_W] = start;
		word[IN_RUN_BIT]          = run;
		if (!quiet && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= func;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(FUNC_TICK, ID_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
			1'($urandom));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// mostly small slices so tasks run out and get rescheduled often
	function automatic logic [FIELD_W-1:0] pick_amount();
		case ($urandom_range(11))
			0: return '0;
			1: return '1;
			2: return FIELD_W'($urandom);
			default: return FIELD_W'($urandom_range(6, 1));
		endcase
	endfunction

	initial begin
		logic [ID_W-1:0] id;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// priority mode out of reset: empty table, every slice zero
		send_tick();
		send_item(FUNC_WRITE, 5'd0, 16'd5, 16'd7, 1'b1);
		// unready entry whose refill would saturate
		send_item(FUNC_WRITE, 5'd31, 16'hFFFF, 16'hFFFF, 1'b0);
		send_item(FUNC_WRITE, 5'd1, 16'hFFFF, 16'hFFFF, 1'b1);
		send_item(FUNC_WRITE, 5'd2, 16'd3, 16'd2, 1'b1);
		send_item(FUNC_WRITE, 5'd3, 16'd3, 16'd2, 1'b1);
		send_tick();
		send_tick();
		send_item(FUNC_WRITE, 5'd1, 16'd0, 16'd1, 1'b1);
		// slice runs out, tie between 2 and 3 goes to 2
		send_tick();
		send_item(FUNC_WRITE, 5'd2, 16'd3, 16'd0, 1'b1);
		// running task already at zero
		send_tick();
		send_tick();
		send_tick();
		send_item(FUNC_WRITE, 5'd3, 16'd0, 16'd0, 1'b0);
		drain();

		// sjf with nothing eligible
		write_reg(CFG_MODE, 16'd1);
		write_reg(CFG_MAX_SLICE, 16'd0);
		send_tick();
		send_item(FUNC_WRITE, 5'd2, 16'd0, 16'd0, 1'b1);
		send_tick();
		drain();

		write_reg(CFG_MAX_SLICE, 16'hFFFF);
		send_item(FUNC_WRITE, 5'd4, 16'd2, 16'd9, 1'b1);
		send_item(FUNC_WRITE, 5'd5, 16'd4, 16'd9, 1'b1);
		send_item(FUNC_WRITE, 5'd6, 16'd9, 16'd0, 1'b1);
		send_tick();
		send_item(FUNC_WRITE, 5'd4, 16'd2, 16'd1, 1'b1);
		send_tick();
		send_item(FUNC_WRITE, 5'd5, 16'd4, 16'd0, 1'b1);
		send_tick();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			quiet = (p == PHASES - 1);
			write_reg(CFG_MODE, CFG_DATA_W'(p % 2));
			case (p)
				1: write_reg(CFG_MAX_SLICE, 16'd0);
				2: write_reg(CFG_MAX_SLICE, 16'hFFFF);
				default: write_reg(CFG_MAX_SLICE, $urandom_range(1) ?
					CFG_DATA_W'($urandom_range(12)) : CFG_DATA_W'($urandom));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 55) begin
					send_tick();
				end else begin
					id = ($urandom_range(9) < 7) ? ID_W'($urandom_range(6, 1))
						: ID_W'($urandom_range(TASK_COUNT - 1));
					send_item(FUNC_WRITE, id, pick_amount(), pick_amount(),
						$urandom_range(99) < 85);
				end
			end
			drain();
		end

		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
